// File: sv/wsfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_pkg
// Shared types and constants of the WebSocket frame receiver.
// ----------------------------------------------------------------------------
package wsfr_pkg;

  localparam int unsigned LIMIT_W = 24;
  localparam logic [LIMIT_W-1:0] MAX_MSG_RESET = 24'd65536;
  localparam logic [6:0] PONG_CAP = 7'd125;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_BYTES = 4'd4;

  localparam int unsigned PADDR_W = 3;
  localparam logic REG_MAX_MSG = 1'b0;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [2:0] EV_DATA       = 3'd0;
  localparam logic [2:0] EV_PONG_START = 3'd1;
  localparam logic [2:0] EV_PONG_DATA  = 3'd2;
  localparam logic [2:0] EV_PONG_RECV  = 3'd3;
  localparam logic [2:0] EV_CLOSE      = 3'd4;

  localparam logic [1:0] CR_NORMAL   = 2'd0;
  localparam logic [1:0] CR_PROTOCOL = 2'd1;
  localparam logic [1:0] CR_UNSUPP   = 2'd2;
  localparam logic [1:0] CR_TOOBIG   = 2'd3;

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    logic [6:0] pong_length;
    logic [1:0] close_reason;
  } result_t;

endpackage
`default_nettype wire

// File: sv/wsfr_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_regs
// APB-style configuration register holding the message size limit.
// ----------------------------------------------------------------------------
module wsfr_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wsfr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output logic      [wsfr_pkg::LIMIT_W-1:0] max_message_bytes
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready &&
                  (paddr[2] == wsfr_pkg::REG_MAX_MSG);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_bytes <= wsfr_pkg::MAX_MSG_RESET;
    end else if (wr_en) begin
      max_message_bytes <= pwdata[wsfr_pkg::LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == wsfr_pkg::REG_MAX_MSG) begin
      prdata = {{(32 - wsfr_pkg::LIMIT_W){1'b0}}, max_message_bytes};
    end
  end

endmodule
`default_nettype wire

// File: sv/wsfr_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_parser
// Frame header parser, checks, payload unmasking; one byte per accepted cycle.
// ----------------------------------------------------------------------------
module wsfr_parser (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire logic [7:0]                   rx_byte,
  input  wire logic [wsfr_pkg::LIMIT_W-1:0] max_message_bytes,
  output logic                              res_valid,
  output wsfr_pkg::result_t                 res
);

  wsfr_pkg::phase_t phase, phase_next;
  logic        final_flag, final_flag_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic [3:0]  header_byte_count, header_byte_count_next;
  logic [63:0] frame_length, frame_length_next;
  logic [31:0] mask_key, mask_key_next;
  logic [23:0] payload_left, payload_left_next;
  logic [1:0]  mask_idx, mask_idx_next;
  logic [6:0]  payload_position, payload_position_next;
  logic [6:0]  pong_len, pong_len_next;
  logic [23:0] fragment_count, fragment_count_next;
  logic        closed, closed_next;
  logic        masked_flag, masked_flag_next;

  logic        len_done;
  logic        len_masked;
  logic        hdr_done;
  logic [63:0] fl;
  logic        len_big;
  logic [24:0] frag_sum;
  logic        frag_big;
  logic [7:0]  key;
  logic [7:0]  unmasked;
  logic        done;
  logic [6:0]  pos_inc;

  always_comb begin
    phase_next             = phase;
    final_flag_next        = final_flag;
    frame_opcode_next      = frame_opcode;
    header_byte_count_next = header_byte_count;
    frame_length_next      = frame_length;
    mask_key_next          = mask_key;
    payload_left_next      = payload_left;
    mask_idx_next          = mask_idx;
    payload_position_next  = payload_position;
    pong_len_next          = pong_len;
    fragment_count_next    = fragment_count;
    closed_next            = closed;
    masked_flag_next       = masked_flag;
    res_valid              = 1'b0;
    res                    = '0;
    len_done               = 1'b0;
    len_masked             = masked_flag;
    hdr_done               = 1'b0;
    fl                     = frame_length;

    case (mask_idx)
      2'd0:    key = mask_key[31:24];
      2'd1:    key = mask_key[23:16];
      2'd2:    key = mask_key[15:8];
      default: key = mask_key[7:0];
    endcase
    unmasked = rx_byte ^ key;
    done     = (payload_left == 24'd1);
    pos_inc  = payload_position + 7'd1;

    if (accept && !closed) begin
      case (phase)
        wsfr_pkg::PH_HDR0: begin
          final_flag_next   = rx_byte[7];
          frame_opcode_next = rx_byte[3:0];
          phase_next        = wsfr_pkg::PH_HDR1;
        end
        wsfr_pkg::PH_HDR1: begin
          masked_flag_next = rx_byte[7];
          len_masked       = rx_byte[7];
          if (rx_byte[6:0] == wsfr_pkg::LEN7_EXT16 ||
              rx_byte[6:0] == wsfr_pkg::LEN7_EXT64) begin
            header_byte_count_next = (rx_byte[6:0] == wsfr_pkg::LEN7_EXT16) ?
                                     wsfr_pkg::EXT16_BYTES : wsfr_pkg::EXT64_BYTES;
            frame_length_next      = 64'd0;
            phase_next             = wsfr_pkg::PH_EXTLEN;
          end else begin
            frame_length_next = {57'd0, rx_byte[6:0]};
            len_done          = 1'b1;
          end
        end
        wsfr_pkg::PH_EXTLEN: begin
          frame_length_next      = {frame_length[55:0], rx_byte};
          header_byte_count_next = header_byte_count - 4'd1;
          len_done               = (header_byte_count == 4'd1);
        end
        wsfr_pkg::PH_MASK: begin
          mask_key_next          = {mask_key[23:0], rx_byte};
          header_byte_count_next = header_byte_count - 4'd1;
          hdr_done               = (header_byte_count == 4'd1);
        end
        wsfr_pkg::PH_PAYLOAD: begin
          payload_left_next = payload_left - 24'd1;
          mask_idx_next     = mask_idx + 2'd1;
          if (done) begin
            phase_next = wsfr_pkg::PH_HDR0;
          end
          if (frame_opcode == wsfr_pkg::OP_CONT || frame_opcode == wsfr_pkg::OP_TEXT) begin
            res_valid      = 1'b1;
            res.event_res  = wsfr_pkg::EV_DATA;
            res.data_byte  = unmasked;
            res.byte_valid = 1'b1;
            res.last       = final_flag && done;
          end else if (frame_opcode == wsfr_pkg::OP_PING && payload_position < pong_len) begin
            payload_position_next = pos_inc;
            res_valid             = 1'b1;
            res.event_res         = wsfr_pkg::EV_PONG_DATA;
            res.data_byte         = unmasked;
            res.byte_valid        = 1'b1;
            res.last              = (pos_inc == pong_len);
          end
        end
        default: begin
          phase_next = wsfr_pkg::PH_HDR0;
        end
      endcase

      if (len_done) begin
        if (!len_masked) begin
          closed_next      = 1'b1;
          res_valid        = 1'b1;
          res.event_res    = wsfr_pkg::EV_CLOSE;
          res.close_reason = wsfr_pkg::CR_PROTOCOL;
        end else begin
          phase_next             = wsfr_pkg::PH_MASK;
          header_byte_count_next = wsfr_pkg::MASK_BYTES;
          mask_key_next          = 32'd0;
        end
      end
    end

    len_big  = (|frame_length[63:24]) || (frame_length[23:0] > max_message_bytes);
    frag_sum = {1'b0, fragment_count} + {1'b0, frame_length[23:0]};
    frag_big = frag_sum > {1'b0, max_message_bytes};

    if (hdr_done) begin
      payload_left_next     = frame_length[23:0];
      mask_idx_next         = 2'd0;
      payload_position_next = 7'd0;
      pong_len_next         = (frame_length > {57'd0, wsfr_pkg::PONG_CAP}) ?
                              wsfr_pkg::PONG_CAP : frame_length[6:0];
      phase_next            = (fl != 64'd0) ? wsfr_pkg::PH_PAYLOAD : wsfr_pkg::PH_HDR0;
      res_valid             = 1'b1;
      if (len_big) begin
        closed_next      = 1'b1;
        res.event_res    = wsfr_pkg::EV_CLOSE;
        res.close_reason = wsfr_pkg::CR_TOOBIG;
      end else begin
        case (frame_opcode)
          wsfr_pkg::OP_CONT, wsfr_pkg::OP_TEXT: begin
            if (frame_opcode == wsfr_pkg::OP_TEXT && fragment_count != 24'd0) begin
              closed_next      = 1'b1;
              res.event_res    = wsfr_pkg::EV_CLOSE;
              res.close_reason = wsfr_pkg::CR_PROTOCOL;
            end else if (frag_big) begin
              closed_next      = 1'b1;
              res.event_res    = wsfr_pkg::EV_CLOSE;
              res.close_reason = wsfr_pkg::CR_TOOBIG;
            end else begin
              fragment_count_next = final_flag ? 24'd0 : frag_sum[23:0];
              res_valid           = final_flag && (fl == 64'd0);
              res.event_res       = wsfr_pkg::EV_DATA;
              res.last            = 1'b1;
            end
          end
          wsfr_pkg::OP_BIN: begin
            closed_next      = 1'b1;
            res.event_res    = wsfr_pkg::EV_CLOSE;
            res.close_reason = wsfr_pkg::CR_UNSUPP;
          end
          wsfr_pkg::OP_CLOSE: begin
            closed_next      = 1'b1;
            res.event_res    = wsfr_pkg::EV_CLOSE;
            res.close_reason = wsfr_pkg::CR_NORMAL;
          end
          wsfr_pkg::OP_PING: begin
            res.event_res   = wsfr_pkg::EV_PONG_START;
            res.pong_length = pong_len_next;
          end
          wsfr_pkg::OP_PONG: begin
            res.event_res = wsfr_pkg::EV_PONG_RECV;
          end
          default: begin
            closed_next      = 1'b1;
            res.event_res    = wsfr_pkg::EV_CLOSE;
            res.close_reason = wsfr_pkg::CR_PROTOCOL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= wsfr_pkg::PH_HDR0;
      final_flag        <= 1'b0;
      frame_opcode      <= 4'd0;
      header_byte_count <= 4'd0;
      frame_length      <= 64'd0;
      mask_key          <= 32'd0;
      payload_left      <= 24'd0;
      mask_idx          <= 2'd0;
      payload_position  <= 7'd0;
      pong_len          <= 7'd0;
      fragment_count    <= 24'd0;
      closed            <= 1'b0;
      masked_flag       <= 1'b0;
    end else begin
      phase             <= phase_next;
      final_flag        <= final_flag_next;
      frame_opcode      <= frame_opcode_next;
      header_byte_count <= header_byte_count_next;
      frame_length      <= frame_length_next;
      mask_key          <= mask_key_next;
      payload_left      <= payload_left_next;
      mask_idx          <= mask_idx_next;
      payload_position  <= payload_position_next;
      pong_len          <= pong_len_next;
      fragment_count    <= fragment_count_next;
      closed            <= closed_next;
      masked_flag       <= masked_flag_next;
    end
  end

  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    closed |=> closed)
    else $error("closed flag cleared without reset");

  a_silent_when_closed: assert property (@(posedge clk) disable iff (rst)
    closed |-> !res_valid)
    else $error("result produced after close");

  a_payload_pending: assert property (@(posedge clk) disable iff (rst)
    (phase == wsfr_pkg::PH_PAYLOAD && !closed) |-> (payload_left != 24'd0))
    else $error("payload phase with no bytes left");

  a_close_sets_flag: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.event_res == wsfr_pkg::EV_CLOSE) |=> closed)
    else $error("close event without closing the connection");

endmodule
`default_nettype wire

// File: sv/wsfr_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_out_queue
// Two-entry result queue that decouples the parser from output stalls.
// ----------------------------------------------------------------------------
module wsfr_out_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire wsfr_pkg::result_t push_res,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output wsfr_pkg::result_t      head
);

  logic [1:0]        count, count_next;
  wsfr_pkg::result_t slot1;
  logic              pop;
  logic [1:0]        wr_idx;

  assign out_valid  = (count != 2'd0);
  assign full       = (count == 2'd2);
  assign pop        = out_valid && !out_stall;
  assign wr_idx     = count - {1'b0, pop};
  assign count_next = count + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && wr_idx == 2'd0) begin
      head <= push_res;
    end else if (pop) begin
      head <= slot1;
    end
    if (push && wr_idx != 2'd0) begin
      slot1 <= push_res;
    end
  end

endmodule
`default_nettype wire

// File: sv/websocket_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// Parses and unmasks a client-to-server WebSocket byte stream into events.
// ----------------------------------------------------------------------------
// Output: a result enters the queue in the cycle its byte is accepted and
// is offered from the registered queue head. Throughput: one byte per cycle
// while in_stall is low; a two-entry result queue absorbs output stalls.
// Reset: synchronous; the parser returns to the first header byte with the
// connection open, and the size limit returns to 65536 bytes.
// ----------------------------------------------------------------------------
module websocket_frame_receiver (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wsfr_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [2:0]                    event_res,
  output logic      [7:0]                    data_byte,
  output logic                               byte_valid,
  output logic                               last,
  output logic      [6:0]                    pong_length,
  output logic      [1:0]                    close_reason
);

  logic [wsfr_pkg::LIMIT_W-1:0] max_message_bytes;
  logic                         accept;
  logic                         res_valid;
  wsfr_pkg::result_t            res;
  wsfr_pkg::result_t            head;
  logic                         full;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  wsfr_regs u_regs (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .max_message_bytes (max_message_bytes)
  );

  wsfr_parser u_parser (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .rx_byte           (rx_byte),
    .max_message_bytes (max_message_bytes),
    .res_valid         (res_valid),
    .res               (res)
  );

  wsfr_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_res  (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign event_res    = head.event_res;
  assign data_byte    = head.data_byte;
  assign byte_valid   = head.byte_valid;
  assign last         = head.last;
  assign pong_length  = head.pong_length;
  assign close_reason = head.close_reason;

endmodule
`default_nettype wire
